FILE: hdl/tdw_pkg.sv
// ============================================================================
// tdw_pkg: shared types and constants for the display dirty-span writer
// Request codes, sequencer states and display command constants.
// ============================================================================
`default_nettype none

package tdw_pkg;

   // Kinds of input requests.
   typedef enum logic [1:0] {
      REQ_ROW_WORD   = 2'd0,
      REQ_INVALIDATE = 2'd1,
      REQ_COMMIT     = 2'd2,
      REQ_CLEAR      = 2'd3
   } req_kind_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP_RD,
      ST_CMP_CHK,
      ST_CURSOR,
      ST_DATA,
      ST_CLEAR
   } state_type;

   localparam logic [7:0] CMD_CLEAR     = 8'h01;
   localparam logic [7:0] LONG_WAIT_MAX = 8'h03;
   localparam logic [2:0] CLOSE_WORD    = 3'd7;

   // Cursor base address of each display row.
   function automatic logic [7:0] row_base(input logic [1:0] row);
      logic [7:0] base;
      case (row)
         2'd0:    base = 8'hC0;
         2'd1:    base = 8'hD0;
         2'd2:    base = 8'hC8;
         2'd3:    base = 8'hD8;
         default: base = 8'hC0;
      endcase
      return base;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/tdw_if.sv
// ============================================================================
// tdw_if: request and response channel interfaces
// Valid/ready channels carrying the input words and the display bus bytes.
// ============================================================================
`default_nettype none

interface tdw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [1:0]  row;
   logic [2:0]  word_index;
   logic [15:0] char_pair;

   modport source (output valid, output req_type, output row, output word_index,
                   output char_pair, input ready);
   modport sink   (input valid, input req_type, input row, input word_index,
                   input char_pair, output ready);
endinterface

interface tdw_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_data;
   logic [7:0] bus_byte;
   logic       long_wait;
   logic       last_of_run;

   modport source (output valid, output is_data, output bus_byte, output long_wait,
                   output last_of_run, input ready);
   modport sink   (input valid, input is_data, input bus_byte, input long_wait,
                   input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: hdl/text_display_dirty_span_writer.sv
// ============================================================================
// text_display_dirty_span_writer: dirty-span writer for a character display
// Stages one display row word by word, compares it with a shadow copy and
// sends only the changed span (or the whole row) as bus bytes.
// ============================================================================
//
//   channel  | direction | carries
//   ---------+-----------+----------------------------------------------------
//   req_ch   | in        | request kind, row, word index, character pair
//   rsp_ch   | out       | command/data flag, bus byte, long wait, last of run
//
// Row-word, invalidate and commit requests are handled in the idle state; a
// clear also sends one byte. Word 7 of an existing row starts the sequencer:
// with a valid shadow it compares COL_COUNT/2 words (read, then check), then
// sends one byte per cycle (cursor plus up to 16 data bytes) as the output
// register drains. Ready stays low until the last byte is loaded. Synchronous
// reset; per-word valid bits make unwritten shadow words read 0: no clear pass.

`default_nettype none

module text_display_dirty_span_writer #(
   parameter int ROW_COUNT = 4,
   parameter int COL_COUNT = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   tdw_req_if.sink     req_ch,
   tdw_rsp_if.source   rsp_ch
);

   // Shadow memory holds one 16-bit word per row position.
   localparam int DEPTH  = ROW_COUNT * 8;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int NWORDS = COL_COUNT / 2;
   localparam logic [2:0] CMP_LAST = 3'(NWORDS - 1);
   localparam logic [3:0] FULL_END_COL = 4'(COL_COUNT - 1);
   localparam logic [2:0] ROW_LIMIT = 3'(ROW_COUNT);

   tdw_pkg::state_type state_ff, state_in;

   logic [15:0] stage_ff [8];
   logic        shadow_current_ff, shadow_current_in;

   logic [15:0]       shadow_mem [DEPTH];
   logic [DEPTH-1:0]  entry_vld_ff;
   logic [15:0]       rd_data_ff;
   logic              rd_vld_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic              wr_en;

   logic [1:0] row_ff, row_in;
   logic [2:0] word_ff, word_in;
   logic [2:0] first_ff, first_in;
   logic [2:0] last_ff, last_in;
   logic       any_ff, any_in;
   logic       full_ff, full_in;
   logic [3:0] col_ff, col_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_data_ff, rsp_data_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_long_ff, rsp_long_in;
   logic       rsp_last_ff, rsp_last_in;

   logic        req_fire;
   logic        slot_free;
   logic        load;
   logic        ld_data;
   logic [7:0]  ld_byte;
   logic        ld_last;
   logic [15:0] cur_word;
   logic [15:0] old_word;
   logic        word_diff;
   logic [3:0]  end_col;

   assign req_ch.ready = (state_ff == tdw_pkg::ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.is_data     = rsp_data_ff;
   assign rsp_ch.bus_byte    = rsp_byte_ff;
   assign rsp_ch.long_wait   = rsp_long_ff;
   assign rsp_ch.last_of_run = rsp_last_ff;

   // The shadow port reads the word being compared; the write goes to the word
   // whose low byte is being sent.
   assign rd_addr  = ADDR_W'({row_ff, word_ff});
   assign wr_addr  = ADDR_W'({row_ff, col_ff[3:1]});
   assign cur_word = stage_ff[word_ff];
   assign old_word = rd_vld_ff ? rd_data_ff : 16'h0000;
   assign word_diff = (cur_word != old_word);
   assign end_col  = full_ff ? FULL_END_COL : {last_ff, 1'b1};

   // Next state, sequencer bookkeeping and output loading.
   always_comb begin
      state_in          = state_ff;
      shadow_current_in = shadow_current_ff;
      row_in            = row_ff;
      word_in           = word_ff;
      first_in          = first_ff;
      last_in           = last_ff;
      any_in            = any_ff;
      full_in           = full_ff;
      col_in            = col_ff;
      load              = 1'b0;
      ld_data           = 1'b0;
      ld_byte           = 8'h00;
      ld_last           = 1'b0;
      wr_en             = 1'b0;

      case (state_ff)
         tdw_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (tdw_pkg::req_kind_type'(req_ch.req_type))
                  tdw_pkg::REQ_ROW_WORD: begin
                     // Only the last word of an existing row closes the row.
                     if (req_ch.word_index == tdw_pkg::CLOSE_WORD &&
                         {1'b0, req_ch.row} < ROW_LIMIT) begin
                        row_in = req_ch.row;
                        if (shadow_current_ff) begin
                           word_in  = 3'd0;
                           any_in   = 1'b0;
                           full_in  = 1'b0;
                           state_in = tdw_pkg::ST_CMP_RD;
                        end else begin
                           first_in = 3'd0;
                           full_in  = 1'b1;
                           state_in = tdw_pkg::ST_CURSOR;
                        end
                     end
                  end
                  tdw_pkg::REQ_INVALIDATE: shadow_current_in = 1'b0;
                  tdw_pkg::REQ_COMMIT:     shadow_current_in = 1'b1;
                  tdw_pkg::REQ_CLEAR: begin
                     shadow_current_in = 1'b0;
                     state_in          = tdw_pkg::ST_CLEAR;
                  end
                  default: ;
               endcase
            end
         end
         tdw_pkg::ST_CMP_RD: begin
            state_in = tdw_pkg::ST_CMP_CHK;
         end
         tdw_pkg::ST_CMP_CHK: begin
            if (word_diff) begin
               if (!any_ff) begin
                  first_in = word_ff;
               end
               any_in  = 1'b1;
               last_in = word_ff;
            end
            if (word_ff == CMP_LAST) begin
               // No changed word means nothing goes out.
               state_in = (any_ff || word_diff) ? tdw_pkg::ST_CURSOR : tdw_pkg::ST_IDLE;
            end else begin
               word_in  = word_ff + 3'd1;
               state_in = tdw_pkg::ST_CMP_RD;
            end
         end
         tdw_pkg::ST_CURSOR: begin
            if (slot_free) begin
               load     = 1'b1;
               ld_byte  = tdw_pkg::row_base(row_ff) + {5'b00000, first_ff};
               col_in   = {first_ff, 1'b0};
               state_in = tdw_pkg::ST_DATA;
            end
         end
         tdw_pkg::ST_DATA: begin
            if (slot_free) begin
               load    = 1'b1;
               ld_data = 1'b1;
               ld_byte = col_ff[0] ? stage_ff[col_ff[3:1]][15:8]
                                   : stage_ff[col_ff[3:1]][7:0];
               wr_en   = !col_ff[0];
               if (col_ff == end_col) begin
                  ld_last  = 1'b1;
                  state_in = tdw_pkg::ST_IDLE;
               end else begin
                  col_in = col_ff + 4'd1;
               end
            end
         end
         tdw_pkg::ST_CLEAR: begin
            if (slot_free) begin
               load     = 1'b1;
               ld_byte  = tdw_pkg::CMD_CLEAR;
               ld_last  = 1'b1;
               state_in = tdw_pkg::ST_IDLE;
            end
         end
         default: state_in = tdw_pkg::ST_IDLE;
      endcase

      // Output register: load a new byte or drop the one just taken.
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_long_in  = rsp_long_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = ld_data;
         rsp_byte_in  = ld_byte;
         rsp_long_in  = !ld_data && (ld_byte <= tdw_pkg::LONG_WAIT_MAX);
         rsp_last_in  = ld_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= tdw_pkg::ST_IDLE;
         shadow_current_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         any_ff            <= 1'b0;
         full_ff           <= 1'b0;
      end else begin
         state_ff          <= state_in;
         shadow_current_ff <= shadow_current_in;
         rsp_valid_ff      <= rsp_valid_in;
         any_ff            <= any_in;
         full_ff           <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      word_ff     <= word_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      col_ff      <= col_in;
      rsp_data_ff <= rsp_data_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_long_ff <= rsp_long_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Staging row: every row-word request writes its word, whatever the row.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            stage_ff[i] <= 16'h0000;
         end
      end else if (req_fire &&
                   tdw_pkg::req_kind_type'(req_ch.req_type) == tdw_pkg::REQ_ROW_WORD) begin
         stage_ff[req_ch.word_index] <= req_ch.char_pair;
      end
   end

   // Shadow memory with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         shadow_mem[wr_addr] <= stage_ff[col_ff[3:1]];
      end
      rd_data_ff <= shadow_mem[rd_addr];
   end

   // A word never written reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            entry_vld_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= entry_vld_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: test/text_display_dirty_span_writer_tb.sv
// ============================================================================
// text_display_dirty_span_writer_tb: self-checking bench for the span writer
// Streams row words, shadow control and clear requests into the block with
// random gaps and back-pressure, predicts every bus byte and compares each
// response with the oldest predicted byte.
// ============================================================================
`default_nettype none

localparam int DISPLAY_ROWS = 4;
localparam int DISPLAY_COLS = 16;

// Cursor command base of rows 0..3, row 0 in the low byte.
localparam logic [3:0][7:0] CURSOR_BASE = {8'hD8, 8'hC8, 8'hD0, 8'hC0};

typedef struct packed {
   logic       is_data;
   logic [7:0] bus_byte;
   logic       long_wait;
   logic       last_of_run;
} bus_beat_type;

// Tracks the display shadow and the staging row, and holds the bus bytes that
// the block still owes.
class span_scoreboard;
   bus_beat_type expected_beats[$];
   bus_beat_type run_beats[$];
   logic [7:0]   shadow_text [64];
   logic [15:0]  staging_words [8];
   bit           shadow_current;
   int           errors;

   function new();
      foreach (shadow_text[i]) shadow_text[i] = 8'h00;
      foreach (staging_words[i]) staging_words[i] = 16'h0000;
      shadow_current = 1'b0;
      errors = 0;
   endfunction

   function int pending();
      return expected_beats.size();
   endfunction

   function logic [15:0] shadow_word(logic [1:0] row, int w);
      int base;
      base = int'(row) * 16 + 2 * w;
      return {shadow_text[base + 1], shadow_text[base]};
   endfunction

   function logic [7:0] staged_byte(int col);
      logic [15:0] w;
      w = staging_words[(col >> 1) & 7];
      return (col & 1) ? w[15:8] : w[7:0];
   endfunction

   function void add_beat(logic is_data, logic [7:0] value);
      bus_beat_type b;
      b.is_data     = is_data;
      b.bus_byte    = value;
      b.long_wait   = !is_data && (value <= tdw_pkg::LONG_WAIT_MAX);
      b.last_of_run = 1'b0;
      run_beats.push_back(b);
   endfunction

   // Closing a row: the whole row when the shadow is stale, otherwise only
   // the span from the first to the last changed word.
   function void close_row(logic [1:0] row);
      int         base;
      int         first;
      int         last;
      bit         any;
      logic [7:0] lo;
      logic [7:0] hi;
      base = int'(row) * 16;
      if (!shadow_current) begin
         add_beat(1'b0, CURSOR_BASE[row]);
         for (int c = 0; c < DISPLAY_COLS && c < 16; c++) begin
            lo = staged_byte(c);
            add_beat(1'b1, lo);
            shadow_text[base + c] = lo;
         end
      end else begin
         any   = 1'b0;
         first = 0;
         last  = 0;
         for (int w = 0; w < DISPLAY_COLS / 2 && w < 8; w++) begin
            if (staged_byte(2 * w) != shadow_text[base + 2 * w] ||
                staged_byte(2 * w + 1) != shadow_text[base + 2 * w + 1]) begin
               if (!any) first = w;
               any  = 1'b1;
               last = w;
            end
         end
         if (any) begin
            add_beat(1'b0, CURSOR_BASE[row] + 8'(first));
            for (int w = first; w <= last; w++) begin
               lo = staged_byte(2 * w);
               hi = staged_byte(2 * w + 1);
               add_beat(1'b1, lo);
               add_beat(1'b1, hi);
               shadow_text[base + 2 * w]     = lo;
               shadow_text[base + 2 * w + 1] = hi;
            end
         end
      end
   endfunction

   function void note_request(tdw_pkg::req_kind_type kind, logic [1:0] row,
                              logic [2:0] word_index, logic [15:0] char_pair);
      run_beats.delete();
      case (kind)
         tdw_pkg::REQ_INVALIDATE: shadow_current = 1'b0;
         tdw_pkg::REQ_COMMIT:     shadow_current = 1'b1;
         tdw_pkg::REQ_CLEAR: begin
            add_beat(1'b0, tdw_pkg::CMD_CLEAR);
            shadow_current = 1'b0;
         end
         default: begin
            staging_words[word_index] = char_pair;
            if (word_index == tdw_pkg::CLOSE_WORD && int'(row) < DISPLAY_ROWS)
               close_row(row);
         end
      endcase
      if (run_beats.size() > 0) run_beats[run_beats.size() - 1].last_of_run = 1'b1;
      foreach (run_beats[i]) expected_beats.push_back(run_beats[i]);
   endfunction

   task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
   endtask

   task check_response(bus_beat_type got);
      bus_beat_type want;
      if (expected_beats.size() == 0) begin
         report($sformatf("unexpected byte %h is_data %b", got.bus_byte, got.is_data));
      end else begin
         want = expected_beats.pop_front();
         if (got.is_data !== want.is_data)
            report($sformatf("is_data %b, expected %b", got.is_data, want.is_data));
         if (got.bus_byte !== want.bus_byte)
            report($sformatf("bus_byte %h, expected %h", got.bus_byte, want.bus_byte));
         if (got.long_wait !== want.long_wait)
            report($sformatf("long_wait %b, expected %b", got.long_wait, want.long_wait));
         if (got.last_of_run !== want.last_of_run)
            report($sformatf("last_of_run %b, expected %b", got.last_of_run,
                             want.last_of_run));
      end
   endtask
endclass

module text_display_dirty_span_writer_tb;

   // The cycle limit lies far above what the slowest legal run needs.
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_ITEMS = 64;

   logic clock;
   logic reset;

   tdw_req_if req_ch ();
   tdw_rsp_if rsp_ch ();

   text_display_dirty_span_writer #(
      .ROW_COUNT (DISPLAY_ROWS),
      .COL_COUNT (DISPLAY_COLS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   span_scoreboard sb = new();

   // When calm is set neither side inserts random gaps or stalls.
   bit calm = 1'b0;
   // Raised by the stimulus to ask the receiver for one long hold-off.
   bit hold_off_request = 1'b0;
   int item_count = 0;
   int cycle_count = 0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Watchdog: a run that hangs anywhere ends here as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("text_display_dirty_span_writer regression: fail");
         $finish;
      end
   end

   // Receiver side. The ready decision for the next cycle is made at each
   // edge; the hold-off length is counted here so that the sender keeps
   // pushing requests while the output is blocked.
   int hold_left = 0;
   always @(posedge clock) begin
      if (hold_off_request) begin
         hold_left = HOLD_OFF_CYCLES;
         hold_off_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(99) >= 32);
      end
   end

   // Response monitor: values seen at the edge are the ones from before it,
   // so a byte is taken exactly when valid and ready were both high.
   always @(posedge clock) begin
      bus_beat_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.is_data     = rsp_ch.is_data;
         got.bus_byte    = rsp_ch.bus_byte;
         got.long_wait   = rsp_ch.long_wait;
         got.last_of_run = rsp_ch.last_of_run;
         sb.check_response(got);
      end
   end

   // Offers one request, with an optional random gap first, and holds it
   // until the block takes it. The scoreboard is told at the accepting edge.
   task automatic send_request(tdw_pkg::req_kind_type kind, logic [1:0] row,
                               logic [2:0] word_index, logic [15:0] char_pair);
      while (!calm && $urandom_range(99) < 32) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= kind;
      req_ch.row        <= row;
      req_ch.word_index <= word_index;
      req_ch.char_pair  <= char_pair;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(kind, row, word_index, char_pair);
      item_count++;
   endtask

   // Sender pause: nothing is offered until every predicted byte has come.
   // The loop waits for the clock before it checks, so that valid is never
   // lowered and raised in the same step.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // A well-formed row update: words 0..6 are mostly left alone or rewritten
   // with what the shadow already holds, some are changed, and word 7 always
   // closes the row. This keeps the spans short and varied, and sometimes
   // empty.
   task automatic refresh_row(logic [1:0] row);
      int          mode;
      logic [15:0] word;
      for (int w = 0; w < 8; w++) begin
         mode = $urandom_range(9);
         if (w != 7 && mode < 3) continue;
         if (mode < 7)
            word = sb.shadow_word(row, w);
         else if (mode == 7)
            word = sb.shadow_word(row, w) ^ (16'h0001 << $urandom_range(15));
         else
            word = 16'($urandom);
         send_request(tdw_pkg::REQ_ROW_WORD, row, 3'(w), word);
      end
   endtask

   // A whole row with random content.
   task automatic fill_row(logic [1:0] row);
      for (int w = 0; w < 8; w++)
         send_request(tdw_pkg::REQ_ROW_WORD, row, 3'(w), 16'($urandom));
   endtask

   initial begin
      int pick;
      int random_start;

      // Every input is known from time zero.
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.req_type   = tdw_pkg::REQ_ROW_WORD;
      req_ch.row        = 2'd0;
      req_ch.word_index = 3'd0;
      req_ch.char_pair  = 16'h0000;
      rsp_ch.ready      = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- Directed part ----
      // Stale shadow after reset: the first closed row goes out whole, with
      // the byte extremes in the data.
      send_request(tdw_pkg::REQ_ROW_WORD, 2'd0, 3'd0, 16'h0000);
      send_request(tdw_pkg::REQ_ROW_WORD, 2'd0, 3'd1, 16'hFFFF);
      send_request(tdw_pkg::REQ_ROW_WORD, 2'd0, 3'd2, 16'h00FF);
      send_request(tdw_pkg::REQ_ROW_WORD, 2'd0, 3'd3, 16'hFF00);
      send_request(tdw_pkg::REQ_ROW_WORD, 2'd0, 3'd4, 16'h5AA5);
      send_request(tdw_pkg::REQ_ROW_WORD, 2'd0, 3'd5, 16'h0102);
      send_request(tdw_pkg::REQ_ROW_WORD, 2'd0, 3'd6, 16'h8001);
      send_request(tdw_pkg::REQ_ROW_WORD, 2'd0, 3'd7, 16'h7FFE);
      // Valid shadow and an unchanged row: nothing is sent.
      send_request(tdw_pkg::REQ_COMMIT, 2'd3, 3'd7, 16'hFFFF);
      send_request(tdw_pkg::REQ_ROW_WORD, 2'd0, 3'd7, 16'h7FFE);
      // Changes at word 3 and word 7: span 3..7.
      send_request(tdw_pkg::REQ_ROW_WORD, 2'd0, 3'd3, 16'h1234);
      send_request(tdw_pkg::REQ_ROW_WORD, 2'd0, 3'd7, 16'hABCD);
      // Same staging row closed on row 1, whose shadow is still zero.
      send_request(tdw_pkg::REQ_ROW_WORD, 2'd1, 3'd7, 16'hABCD);
      // Clear: one long-wait command, and the shadow becomes stale.
      send_request(tdw_pkg::REQ_CLEAR, 2'd2, 3'd5, 16'hA5A5);
      send_request(tdw_pkg::REQ_INVALIDATE, 2'd1, 3'd2, 16'h5A5A);
      // Stale shadow on the last row: full send with the highest cursor base.
      send_request(tdw_pkg::REQ_ROW_WORD, 2'd3, 3'd7, 16'hFFFF);
      // Valid shadow again; row 2 was never written, so it differs widely.
      send_request(tdw_pkg::REQ_COMMIT, 2'd0, 3'd0, 16'h0000);
      send_request(tdw_pkg::REQ_ROW_WORD, 2'd2, 3'd7, 16'h0000);
      // Only the last word changes on row 3: a one-word span at word 7.
      send_request(tdw_pkg::REQ_ROW_WORD, 2'd3, 3'd7, 16'hFFFE);
      wait_drained();

      // ---- Back-pressure ----
      // The receiver blocks for a long stretch while two full rows are
      // offered, so the block fills up and must stall its input.
      hold_off_request = 1'b1;
      send_request(tdw_pkg::REQ_INVALIDATE, 2'd0, 3'd0, 16'h0000);
      fill_row(2'd2);
      fill_row(2'd1);
      send_request(tdw_pkg::REQ_COMMIT, 2'd1, 3'd1, 16'h0001);
      wait_drained();

      // ---- Random part ----
      // Mostly row updates against a valid shadow, with shadow control,
      // clears and stray words mixed in. A middle stretch runs without gaps.
      random_start = item_count;
      while (item_count - random_start < RANDOM_ITEMS) begin
         calm = (item_count - random_start >= 24) && (item_count - random_start < 44);
         pick = $urandom_range(99);
         if (pick < 55)
            refresh_row(2'($urandom_range(3)));
         else if (pick < 62)
            fill_row(2'($urandom_range(3)));
         else if (pick < 74)
            send_request(tdw_pkg::REQ_COMMIT, 2'($urandom), 3'($urandom),
                         16'($urandom));
         else if (pick < 82)
            send_request(tdw_pkg::REQ_INVALIDATE, 2'($urandom), 3'($urandom),
                         16'($urandom));
         else if (pick < 88)
            send_request(tdw_pkg::REQ_CLEAR, 2'($urandom), 3'($urandom),
                         16'($urandom));
         else
            send_request(tdw_pkg::REQ_ROW_WORD, 2'($urandom), 3'($urandom),
                         16'($urandom));
         if ($urandom_range(19) == 0) wait_drained();
      end
      calm = 1'b0;

      // Drain, then give a stray byte time to show up.
      wait_drained();
      repeat (64) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d bytes never arrived", sb.pending()));

      if (sb.errors == 0) begin
         $display("text_display_dirty_span_writer regression: pass");
      end else begin
         $display("text_display_dirty_span_writer regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
